// ===== src/imu_bias_calibrate_scale_assert.svh =====
// assertion macros shared by the checker files
`ifndef IMU_BIAS_CALIBRATE_SCALE_ASSERT_SVH
`define IMU_BIAS_CALIBRATE_SCALE_ASSERT_SVH

// consequence must hold in the cycle after the antecedent
`define IBCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ibcs assertion failed");

// consequence must hold in the same cycle as the antecedent
`define IBCS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ibcs assertion failed");

`endif

// ===== src/ibcs_pkg.sv =====
package ibcs_pkg;

  // axes carried by every sample
  localparam int unsigned NumInAxes  = 6;
  localparam int unsigned NumAccAxes = 3;
  localparam int unsigned AxesDefault = 6;
  localparam int unsigned AxisW      = 3;

  // field widths
  localparam int unsigned RawW   = 16;
  localparam int unsigned SumW   = 26;
  localparam int unsigned OffW   = 16;
  localparam int unsigned CalW   = 10;
  localparam int unsigned CntW   = 11;
  localparam int unsigned ScaleW = 16;
  localparam int unsigned OutW   = 33;
  localparam int unsigned StepW  = 5;

  // stream and config bus widths
  localparam int unsigned InTdataW  = NumInAxes * RawW;
  localparam int unsigned OutTdataW = ((NumInAxes * OutW + 7) / 8) * 8;
  localparam int unsigned CfgAddrW  = 2;
  localparam int unsigned CfgDataW  = 16;

  // calib_samples of zero means a full run
  localparam int unsigned FullCount = 1024;

  // register reset values
  localparam logic [CalW-1:0]   CalibReset = CalW'(200);
  localparam logic [ScaleW-1:0] AccelReset = ScaleW'(4);
  localparam logic [ScaleW-1:0] GyroReset  = ScaleW'(500);

  typedef enum logic [CfgAddrW-1:0] {
    CFG_CALIB_SAMPLES = 2'd0,
    CFG_ACCEL_SCALE   = 2'd1,
    CFG_GYRO_SCALE    = 2'd2
  } cfg_reg_e;

endpackage

// ===== src/ibcs_div.sv =====
// signed by unsigned divider, one quotient bit per cycle, truncates toward zero
module ibcs_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [ibcs_pkg::SumW-1:0]     dividend_i,
  input  logic        [ibcs_pkg::CntW-1:0]     divisor_i,
  output logic                                 done_o,
  output logic signed [ibcs_pkg::OffW-1:0]     quot_o
);

  logic                           busy_q;
  logic                           done_q;
  logic                           neg_q;
  logic [ibcs_pkg::StepW-1:0]     step_q;
  logic [ibcs_pkg::CntW-1:0]      rem_q;
  logic [ibcs_pkg::SumW-1:0]      quo_q;

  logic [ibcs_pkg::SumW-1:0]      mag;
  logic [ibcs_pkg::CntW:0]        shifted;
  logic [ibcs_pkg::CntW+1:0]      trial;
  logic [ibcs_pkg::SumW-1:0]      quo_signed;

  assign mag     = dividend_i[ibcs_pkg::SumW-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign shifted = {rem_q, quo_q[ibcs_pkg::SumW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && step_q == ibcs_pkg::StepW'(ibcs_pkg::SumW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q  <= dividend_i[ibcs_pkg::SumW-1];
      quo_q  <= mag;
      rem_q  <= '0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      // restoring step: keep the trial remainder when it did not borrow
      if (!trial[ibcs_pkg::CntW+1]) begin
        rem_q <= trial[ibcs_pkg::CntW-1:0];
        quo_q <= {quo_q[ibcs_pkg::SumW-2:0], 1'b1};
      end else begin
        rem_q <= shifted[ibcs_pkg::CntW-1:0];
        quo_q <= {quo_q[ibcs_pkg::SumW-2:0], 1'b0};
      end
    end
  end

  assign quo_signed = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign quot_o     = quo_signed[ibcs_pkg::OffW-1:0];
  assign done_o     = done_q;

endmodule

// ===== src/imu_bias_calibrate_scale.sv =====
// ordinary sample: from accept beat to result beat it passes S_MUL (6 multiply steps), then S_DONE
// a calibration sample passes S_ACC (one add per summed axis) and gives no result; the sample that
// ends calibration then runs the shared divider once per axis below AXES (26 quotient bits, one per
// cycle, plus start and hand-off per axis)
// samples: no new sample is taken before the last one is through; ready stays low while a sample is worked
// reset: calibrating, count cleared and a clear of the sums pending, registers at 200 / 4 / 500, no result pending
module imu_bias_calibrate_scale #(
  parameter int unsigned AXES = ibcs_pkg::AxesDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // sample stream
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
  input  logic [ibcs_pkg::InTdataW-1:0]       s_axis_tdata_i,
  // action
  input  logic                                s_axis_tuser_i,
  // result stream
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // accel_x_out, accel_y_out, accel_z_out, gyro_x_out, gyro_y_out, gyro_z_out, zero pad
  output logic [ibcs_pkg::OutTdataW-1:0]      m_axis_tdata_o,
  // register writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ibcs_pkg::CfgAddrW-1:0]       cfg_addr_i,
  input  logic [ibcs_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int unsigned RawW = ibcs_pkg::RawW;
  localparam int unsigned SumW = ibcs_pkg::SumW;
  localparam int unsigned OffW = ibcs_pkg::OffW;
  localparam int unsigned OutW = ibcs_pkg::OutW;
  localparam int unsigned NumIn = ibcs_pkg::NumInAxes;
  localparam int unsigned AxisW = ibcs_pkg::AxisW;
  localparam int unsigned CntW = ibcs_pkg::CntW;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ACC  = 5'b00010,
    S_DIV  = 5'b00100,
    S_MUL  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  // config registers
  logic [ibcs_pkg::CalW-1:0]   calib_q;
  logic [ibcs_pkg::ScaleW-1:0] accel_q;
  logic [ibcs_pkg::ScaleW-1:0] gyro_q;

  // sequencer and calibration state
  state_e                      state_q;
  logic [AxisW-1:0]            axis_q;
  logic [AxisW-1:0]            div_ax_q;
  logic                        cal_q;
  logic                        clr_q;
  logic                        div_start_q;
  logic [CntW-1:0]             count_q;

  // working lanes, rotated so the shared unit always reads entry 0
  logic signed [RawW-1:0]      raw_q  [NumIn];
  logic signed [SumW-1:0]      sums_q [AXES];
  logic signed [OffW-1:0]      offs_q [AXES];
  logic signed [OutW-1:0]      res_q  [NumIn];

  // output stage
  logic                        out_valid_q;
  logic [ibcs_pkg::OutTdataW-1:0] out_data_q;
  logic [ibcs_pkg::OutTdataW-1:0] res_packed;

  logic                        in_beat;
  logic                        out_load;
  logic                        axis_on;
  logic                        last_axis;
  logic signed [SumW-1:0]      sum_base;
  logic signed [SumW-1:0]      sum_new;
  logic [CntW-1:0]             count_inc;
  logic [CntW-1:0]             target;
  logic signed [RawW:0]        diff;
  logic [ibcs_pkg::ScaleW-1:0] scale;
  logic signed [2*RawW+1:0]    prod;
  logic                        div_done;
  logic signed [OffW-1:0]      div_quot;

  assign in_beat   = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = (state_q == S_IDLE);

  // axes at or above AXES carry no sum and no offset
  assign axis_on   = axis_q < AxisW'(AXES);
  assign last_axis = axis_q == AxisW'(NumIn - 1);

  // shared adder for the running sums; a pending clear restarts from zero
  assign sum_base  = clr_q ? '0 : sums_q[0];
  assign sum_new   = sum_base + {{(SumW - RawW){raw_q[0][RawW-1]}}, raw_q[0]};
  assign count_inc = (clr_q ? '0 : count_q) + 1'b1;
  assign target    = (calib_q == '0) ? CntW'(ibcs_pkg::FullCount) : {1'b0, calib_q};

  // shared subtract and multiply for the scaled outputs
  assign diff  = {raw_q[0][RawW-1], raw_q[0]}
               - (axis_on ? {offs_q[0][OffW-1], offs_q[0]} : '0);
  assign scale = (axis_q < AxisW'(ibcs_pkg::NumAccAxes)) ? accel_q : gyro_q;
  assign prod  = diff * $signed({1'b0, scale});

  // offsets come from the shared divider, sum over sample count
  ibcs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (sums_q[0]),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // register writes land only while idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_q <= ibcs_pkg::CalibReset;
      accel_q <= ibcs_pkg::AccelReset;
      gyro_q  <= ibcs_pkg::GyroReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (ibcs_pkg::cfg_reg_e'(cfg_addr_i))
        ibcs_pkg::CFG_CALIB_SAMPLES: calib_q <= cfg_data_i[ibcs_pkg::CalW-1:0];
        ibcs_pkg::CFG_ACCEL_SCALE:   accel_q <= cfg_data_i;
        ibcs_pkg::CFG_GYRO_SCALE:    gyro_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= '0;
      div_ax_q    <= '0;
      cal_q       <= 1'b1;
      clr_q       <= 1'b1;
      div_start_q <= 1'b0;
      count_q     <= '0;
    end else begin
      div_start_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_beat) begin
            axis_q <= '0;
            // restart: sums and count cleared, this sample is the first one
            if (s_axis_tuser_i) begin
              cal_q <= 1'b1;
              clr_q <= 1'b1;
            end
            state_q <= (cal_q || s_axis_tuser_i) ? S_ACC : S_MUL;
          end
        end
        S_ACC: begin
          axis_q <= axis_q + 1'b1;
          if (last_axis) begin
            count_q <= count_inc;
            clr_q   <= 1'b0;
            if (count_inc >= target) begin
              div_ax_q    <= '0;
              div_start_q <= 1'b1;
              state_q     <= S_DIV;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (div_ax_q == AxisW'(AXES - 1)) begin
              // offsets stored; sums and count are stale from here on
              cal_q   <= 1'b0;
              clr_q   <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              div_ax_q    <= div_ax_q + 1'b1;
              div_start_q <= 1'b1;
            end
          end
        end
        S_MUL: begin
          axis_q <= axis_q + 1'b1;
          if (last_axis) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // lane datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      for (int i = 0; i < NumIn; i++) begin
        raw_q[i] <= s_axis_tdata_i[i*RawW +: RawW];
      end
    end else if (state_q == S_ACC || state_q == S_MUL) begin
      for (int i = 0; i < NumIn - 1; i++) begin
        raw_q[i] <= raw_q[i+1];
      end
      raw_q[NumIn-1] <= raw_q[0];
    end

    // sums rotate once per summed axis, and once per quotient
    if ((state_q == S_ACC && axis_on) || (state_q == S_DIV && div_done)) begin
      for (int i = 0; i < AXES - 1; i++) begin
        sums_q[i] <= sums_q[i+1];
      end
      sums_q[AXES-1] <= (state_q == S_ACC) ? sum_new : sums_q[0];
    end

    // offsets rotate under the multiplier and take quotients at calibration end
    if ((state_q == S_MUL && axis_on) || (state_q == S_DIV && div_done)) begin
      for (int i = 0; i < AXES - 1; i++) begin
        offs_q[i] <= offs_q[i+1];
      end
      offs_q[AXES-1] <= (state_q == S_DIV) ? div_quot : offs_q[0];
    end

    if (state_q == S_MUL) begin
      for (int i = 0; i < NumIn - 1; i++) begin
        res_q[i] <= res_q[i+1];
      end
      res_q[NumIn-1] <= prod[OutW-1:0];
    end
  end

  // output register: a finished result waits here while the next sample comes in
  assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    res_packed = '0;
    for (int i = 0; i < NumIn; i++) begin
      res_packed[i*OutW +: OutW] = res_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= res_packed;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== src/ibcs_checker.sv =====
`include "imu_bias_calibrate_scale_assert.svh"

module ibcs_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic [ibcs_pkg::InTdataW-1:0]    s_axis_tdata_i,
  input logic                             s_axis_tuser_i,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [ibcs_pkg::OutTdataW-1:0]   m_axis_tdata_o,
  input logic                             cfg_valid_i,
  input logic                             cfg_ready_o,
  input logic [ibcs_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input logic [ibcs_pkg::CfgDataW-1:0]    cfg_data_i
);

  // a held result stays offered
  `IBCS_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o)

  // a held result keeps its payload
  `IBCS_ASSERT_NEXT(a_out_stable, m_axis_tvalid_o && !m_axis_tready_i, $stable(m_axis_tdata_o))

  // one sample in flight: ready drops after every input beat
  `IBCS_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)

  // a new result never shows up right after an input beat
  `IBCS_ASSERT_SAME(a_no_early_result, $rose(m_axis_tvalid_o), !$past(s_axis_tvalid_i && s_axis_tready_o))

endmodule

bind imu_bias_calibrate_scale ibcs_checker u_ibcs_checker (.*);
